[hw/rtl/vie_pkg.sv]
`default_nettype none
package vie_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_TAG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_OUI = 1'd1;

	localparam logic [7:0]  VENDOR_TAG_RST = 8'd221;
	localparam logic [23:0] VENDOR_OUI_RST = 24'h01_0203;
	localparam logic [7:0]  MIN_BODY_LEN   = 8'd4;
	localparam logic [7:0]  OUI_BYTES      = 8'd3;
	localparam logic [31:0] MAG_CAP        = 32'h8000_0000;
	localparam logic [31:0] POS_MAX        = 32'h7FFF_FFFF;

	typedef enum logic [1:0] {
		NUM_SKIP,
		NUM_DIGITS,
		NUM_STOP
	} num_phase_t;

	typedef struct packed {
		num_phase_t  phase;
		logic        neg;
		logic [31:0] acc;
	} num_t;

	localparam num_t NUM_RST = '{phase: NUM_SKIP, neg: 1'b0, acc: 32'd0};

	typedef struct packed {
		logic        found;
		logic        truncated;
		logic [31:0] value;
	} res_t;

	function automatic logic [31:0] final_value(input num_t n);
		logic [31:0] v;
		if (n.neg) begin
			v = 32'd0 - n.acc;
		end else if (n.acc > POS_MAX) begin
			v = POS_MAX;
		end else begin
			v = n.acc;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/vie_num.sv]
`default_nettype none
module vie_num
	import vie_pkg::*;
(
	input  wire num_t       cur,
	input  wire logic [7:0] data,
	output num_t            nxt
);

	logic digit;
	logic blank;

	function automatic logic [31:0] take_digit(input logic [31:0] acc, input logic [7:0] b);
		logic [35:0] v;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, b[3:0]};
		return (v > {4'd0, MAG_CAP}) ? MAG_CAP : v[31:0];
	endfunction

	assign digit = data inside {[8'd48:8'd57]};
	assign blank = data inside {8'd32, [8'd9:8'd13]};

	always_comb begin
		nxt = cur;
		case (cur.phase)
			NUM_SKIP: begin
				if (blank) begin
					nxt = cur;
				end else if (data == 8'd43) begin
					nxt.phase = NUM_DIGITS;
				end else if (data == 8'd45) begin
					nxt.neg   = 1'b1;
					nxt.phase = NUM_DIGITS;
				end else if (digit) begin
					nxt.acc   = take_digit(cur.acc, data);
					nxt.phase = NUM_DIGITS;
				end else begin
					nxt.phase = NUM_STOP;
				end
			end
			NUM_DIGITS: begin
				if (digit) begin
					nxt.acc = take_digit(cur.acc, data);
				end else begin
					nxt.phase = NUM_STOP;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/vie_parse.sv]
`default_nettype none
module vie_parse
	import vie_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  data,
	input  wire logic        last,
	input  wire logic [7:0]  vendor_tag,
	input  wire logic [23:0] vendor_oui,
	output res_t             res
);

	typedef enum logic [1:0] {
		PH_TAG,
		PH_LEN,
		PH_BODY
	} field_phase_t;

	field_phase_t phase_q, phase_d;
	logic         tag_matched_q, tag_matched_d;
	logic [7:0]   left_q, left_d;
	logic [7:0]   len_q, len_d;
	logic [7:0]   pos_q, pos_d;
	logic         oui_ok_q, oui_ok_d;
	num_t         num_q, num_d, num_step;
	logic [31:0]  held_q, held_d;
	logic         found_q, found_d;
	logic [7:0]   want;

	vie_num u_num (
		.cur  (num_q),
		.data (data),
		.nxt  (num_step)
	);

	always_comb begin
		case (pos_q[1:0])
			2'd0:    want = vendor_oui[23:16];
			2'd1:    want = vendor_oui[15:8];
			default: want = vendor_oui[7:0];
		endcase
	end

	always_comb begin
		phase_d       = phase_q;
		tag_matched_d = tag_matched_q;
		left_d        = left_q;
		len_d         = len_q;
		pos_d         = pos_q;
		oui_ok_d      = oui_ok_q;
		num_d         = num_q;
		held_d        = held_q;
		found_d       = found_q;
		case (phase_q)
			PH_TAG: begin
				tag_matched_d = (data == vendor_tag);
				phase_d       = PH_LEN;
			end
			PH_LEN: begin
				len_d    = data;
				left_d   = data;
				pos_d    = 8'd0;
				oui_ok_d = 1'b1;
				num_d    = NUM_RST;
				phase_d  = (data == 8'd0) ? PH_TAG : PH_BODY;
			end
			PH_BODY: begin
				if (pos_q < OUI_BYTES) begin
					if (data != want) begin
						oui_ok_d = 1'b0;
					end
				end else begin
					num_d = num_step;
				end
				pos_d  = pos_q + 8'd1;
				left_d = left_q - 8'd1;
				if (left_q == 8'd1) begin
					if (tag_matched_q && (len_q >= MIN_BODY_LEN) && oui_ok_d) begin
						held_d  = final_value(num_d);
						found_d = 1'b1;
					end
					phase_d = PH_TAG;
				end
			end
			default: begin
				phase_d = PH_TAG;
			end
		endcase
	end

	assign res.found     = found_d;
	assign res.truncated = (phase_d != PH_TAG);
	assign res.value     = held_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TAG;
			tag_matched_q <= 1'b0;
			left_q        <= 8'd0;
			len_q         <= 8'd0;
			pos_q         <= 8'd0;
			oui_ok_q      <= 1'b0;
			num_q         <= NUM_RST;
			held_q        <= 32'd0;
			found_q       <= 1'b0;
		end else if (step) begin
			tag_matched_q <= tag_matched_d;
			left_q        <= left_d;
			len_q         <= len_d;
			pos_q         <= pos_d;
			oui_ok_q      <= oui_ok_d;
			num_q         <= num_d;
			held_q        <= held_d;
			if (last) begin
				phase_q <= PH_TAG;
				found_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				found_q <= found_d;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/vendor_ie_ack_extractor.sv]
// an accepted end-of-buffer byte is held in the input register, then its result is registered on the output
// throughput: one byte per cycle while in_stall is low; one parse step per byte between input and result registers
// a final byte waits in the input register only while an earlier result is held off by out_stall
// reset: arst_n clears parser state and handshake flags (the output result registers are not reset) and restores
// vendor_tag 221 and vendor_oui 0x010203
`default_nettype none
module vendor_ie_ack_extractor
	import vie_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            ie_byte,
	input  wire logic                  end_of_buffer,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       ack_found,
	output logic signed [31:0]         ack_value,
	output logic                       truncated,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eob_s1;
	logic        step;
	logic        out_valid_q;
	logic        found_q;
	logic        trunc_q;
	logic [31:0] value_q;
	logic [7:0]  vendor_tag_q;
	logic [23:0] vendor_oui_q;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vendor_tag_q <= VENDOR_TAG_RST;
			vendor_oui_q <= VENDOR_OUI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VENDOR_TAG: vendor_tag_q <= cfg_data[7:0];
				CFG_VENDOR_OUI: vendor_oui_q <= cfg_data[23:0];
				default: begin
					vendor_tag_q <= vendor_tag_q;
				end
			endcase
		end
	end

	assign step     = valid_s1 && (!eob_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= ie_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	vie_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data       (byte_s1),
		.last       (eob_s1),
		.vendor_tag (vendor_tag_q),
		.vendor_oui (vendor_oui_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && eob_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && eob_s1) begin
			found_q <= res.found;
			trunc_q <= res.truncated;
			value_q <= res.value;
		end
	end

	assign out_valid = out_valid_q;
	assign ack_found = found_q;
	assign truncated = trunc_q;
	assign ack_value = value_q;

	// a final byte never overwrites a result that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		step && eob_s1 && out_valid_q |-> !out_stall)
		else $error("result overwritten while held");

	// a new result only follows a final byte
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step && eob_s1))
		else $error("result without final byte");

	// stall only when the input register holds a final byte and an earlier result is still held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && eob_s1 && out_valid_q)
		else $error("stall without pending final byte");

endmodule
`default_nettype wire
